// ===== design/mvscp_pkg.sv =====
package mvscp_pkg;

    // Start code values and prefix bytes
    localparam logic [7:0] PREFIX_ZERO   = 8'h00;
    localparam logic [7:0] PREFIX_ONE    = 8'h01;
    localparam logic [7:0] CODE_SEQ_HDR  = 8'hB3;
    localparam logic [7:0] CODE_GOP      = 8'hB8;
    localparam logic [7:0] CODE_PICTURE  = 8'h00;
    localparam logic [7:0] CODE_SLICE    = 8'h01;

    // Unit kinds reported on the result channel
    localparam logic [2:0] KIND_SEQ   = 3'd0;
    localparam logic [2:0] KIND_GOP   = 3'd1;
    localparam logic [2:0] KIND_PIC   = 3'd2;
    localparam logic [2:0] KIND_SLICE = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;

    // Last header byte index of a sequence header (four bytes after the code)
    localparam logic [1:0] SEQ_LAST_COUNT = 2'd3;

    // One parsed unit
    typedef struct packed {
        logic [2:0]  unit_kind;
        logic [7:0]  start_code_value;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [3:0]  rate_code;
        logic        rate_known;
        logic [2:0]  picture_kind;
        logic        picture_known;
    } mvscp_result_t;

endpackage

// ===== design/mvscp_parser.sv =====
module mvscp_parser
    import mvscp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_in,
    output logic          res_valid,
    output mvscp_result_t res
);

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_CODE,
        PH_SEQ,
        PH_PIC
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [1:0]  fill_reg,    fill_next;
    logic [15:0] window_reg,  window_next;
    logic [23:0] header_reg,  header_next;
    logic [1:0]  count_reg,   count_next;

    logic [3:0]  rate;
    logic [2:0]  pic_type;

    assign rate     = byte_in[3:0];
    assign pic_type = byte_in[5:3];

    // Decode one byte against the current phase
    always_comb
    begin
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        window_next = window_reg;
        header_next = header_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_CODE:
            begin
                count_next  = '0;
                header_next = '0;
                if (byte_in == CODE_SEQ_HDR)
                begin
                    phase_next = PH_SEQ;
                end
                else if (byte_in == CODE_PICTURE)
                begin
                    phase_next = PH_PIC;
                end
                else
                begin
                    res_valid            = 1'b1;
                    res.start_code_value = byte_in;
                    if (byte_in == CODE_GOP)
                        res.unit_kind = KIND_GOP;
                    else if (byte_in == CODE_SLICE)
                        res.unit_kind = KIND_SLICE;
                    else
                        res.unit_kind = KIND_OTHER;
                    phase_next  = PH_SCAN;
                    fill_next   = '0;
                    window_next = '0;
                end
            end

            PH_SEQ:
            begin
                if (count_reg != SEQ_LAST_COUNT)
                begin
                    header_next = {header_reg[15:0], byte_in};
                    count_next  = count_reg + 2'd1;
                end
                else
                begin
                    res_valid            = 1'b1;
                    res.unit_kind        = KIND_SEQ;
                    res.start_code_value = CODE_SEQ_HDR;
                    res.frame_width      = {header_reg[23:16], header_reg[15:12]};
                    res.frame_height     = {header_reg[11:8], header_reg[7:0]};
                    res.rate_code        = rate;
                    res.rate_known       = rate inside {[4'd1:4'd8]};
                    phase_next  = PH_SCAN;
                    fill_next   = '0;
                    window_next = '0;
                    header_next = '0;
                    count_next  = '0;
                end
            end

            PH_PIC:
            begin
                if (count_reg == 2'd0)
                begin
                    header_next = {16'd0, byte_in};
                    count_next  = 2'd1;
                end
                else
                begin
                    res_valid            = 1'b1;
                    res.unit_kind        = KIND_PIC;
                    res.start_code_value = CODE_PICTURE;
                    res.picture_kind     = pic_type;
                    res.picture_known    = pic_type inside {[3'd1:3'd3]};
                    phase_next  = PH_SCAN;
                    fill_next   = '0;
                    window_next = '0;
                    header_next = '0;
                    count_next  = '0;
                end
            end

            default:
            begin
                if (fill_reg == 2'd2 && window_reg == {PREFIX_ZERO, PREFIX_ZERO}
                    && byte_in == PREFIX_ONE)
                begin
                    phase_next  = PH_CODE;
                    fill_next   = '0;
                    window_next = '0;
                end
                else
                begin
                    window_next = {window_reg[7:0], byte_in};
                    if (fill_reg != 2'd2)
                        fill_next = fill_reg + 2'd1;
                end
            end
        endcase
    end

    // Hold parse state, advance on each transfer into the decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCAN;
            fill_reg   <= '0;
            window_reg <= '0;
            header_reg <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            window_reg <= window_next;
            header_reg <= header_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // The window fill never exceeds two bytes
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("window fill out of range");

    // Leaving the code phase always clears the header counter
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_CODE |=> count_reg == 2'd0)
        else $error("header count not cleared after start code");

    // A result always returns the parser to scanning with an empty window
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> phase_reg == PH_SCAN && fill_reg == 2'd0)
        else $error("parser did not restart after a unit");
`endif

endmodule

// ===== design/mpeg_video_start_code_parser_top.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// input    | in_valid / in_ready   | stream_byte
// result   | out_valid / out_ready | unit_kind, start_code_value, frame_width,
//          |                       | frame_height, rate_code, rate_known,
//          |                       | picture_kind, picture_known
//
// One byte per cycle while results are taken: input register, one decode step, result register.
// A unit's last byte goes through the input register, then the result register, before it transfers out.
// A stalled result holds the decoder; one more byte waits in the input register.
// rst_n clears the parse state and both valid flags asynchronously.
module mpeg_video_start_code_parser_top
    import mvscp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  unit_kind,
    output logic [7:0]  start_code_value,
    output logic [11:0] frame_width,
    output logic [11:0] frame_height,
    output logic [3:0]  rate_code,
    output logic        rate_known,
    output logic [2:0]  picture_kind,
    output logic        picture_known
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    mvscp_result_t out_reg;

    logic          advance;
    logic          step;
    logic          res_valid;
    mvscp_result_t res;

    // Decoder may run whenever the result slot is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    mvscp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register: load on transfer, drop when consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= stream_byte;
    end

    // Result register: load a new unit or drain on output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign unit_kind        = out_reg.unit_kind;
    assign start_code_value = out_reg.start_code_value;
    assign frame_width      = out_reg.frame_width;
    assign frame_height     = out_reg.frame_height;
    assign rate_code        = out_reg.rate_code;
    assign rate_known       = out_reg.rate_known;
    assign picture_kind     = out_reg.picture_kind;
    assign picture_known    = out_reg.picture_known;

`ifndef SYNTHESIS
    // A held input byte is not lost while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost during stall");

    // Sequence header results carry their code, others carry no geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_kind == KIND_SEQ |-> start_code_value == CODE_SEQ_HDR)
        else $error("sequence header code mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_kind != KIND_SEQ |->
            frame_width == 12'd0 && frame_height == 12'd0 && !rate_known)
        else $error("geometry set on a non-sequence unit");

    // Picture results carry the picture code and a consistent known flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_kind == KIND_PIC |->
            start_code_value == CODE_PICTURE
            && picture_known == (picture_kind == 3'd1 || picture_kind == 3'd2
                                 || picture_kind == 3'd3))
        else $error("picture result inconsistent");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvscp_pkg::*;

    // Parse phases of the byte-level predictor
    typedef enum logic [2:0] {
        PH_SCAN = 3'd0,
        PH_CODE = 3'd1,
        PH_SEQ  = 3'd2,
        PH_PIC  = 3'd3
    } parse_phase_t;

    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 64;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIRECTED_LEN  = 27;

    // Tracks the stream byte by byte and holds the units still to come out
    class start_code_tracker_t;
        parse_phase_t   phase;
        logic [1:0]     fill;
        logic [15:0]    window;
        logic [23:0]    hdr;
        logic [1:0]     hdr_count;
        mvscp_result_t  awaited_units[$];
        int             errors;
        int             units_checked;
        int             kinds_seen[5];

        function new();
            restart();
            errors = 0;
            units_checked = 0;
            foreach (kinds_seen[i])
                kinds_seen[i] = 0;
        endfunction

        function void restart();
            phase = PH_SCAN;
            fill = 2'd0;
            window = 16'h0;
            hdr = 24'h0;
            hdr_count = 2'd0;
        endfunction

        // Advance the parse state by one accepted byte
        function void note_byte(input logic [7:0] b);
            mvscp_result_t u;
            logic [2:0]    pic_type;
            logic [3:0]    rate;
            bit            emit;
            u = '0;
            emit = 1'b0;
            case (phase)
                PH_CODE:
                begin
                    if (b == CODE_SEQ_HDR)
                    begin
                        phase = PH_SEQ;
                        hdr = 24'h0;
                        hdr_count = 2'd0;
                    end
                    else if (b == CODE_PICTURE)
                    begin
                        phase = PH_PIC;
                        hdr = 24'h0;
                        hdr_count = 2'd0;
                    end
                    else
                    begin
                        u.start_code_value = b;
                        if (b == CODE_GOP)
                            u.unit_kind = KIND_GOP;
                        else if (b == CODE_SLICE)
                            u.unit_kind = KIND_SLICE;
                        else
                            u.unit_kind = KIND_OTHER;
                        emit = 1'b1;
                    end
                end
                PH_SEQ:
                begin
                    if (hdr_count < SEQ_LAST_COUNT)
                    begin
                        hdr = {hdr[15:0], b};
                        hdr_count = hdr_count + 2'd1;
                    end
                    else
                    begin
                        rate = b[3:0];
                        u.unit_kind = KIND_SEQ;
                        u.start_code_value = CODE_SEQ_HDR;
                        u.frame_width = {hdr[23:16], hdr[15:12]};
                        u.frame_height = {hdr[11:8], hdr[7:0]};
                        u.rate_code = rate;
                        u.rate_known = (rate >= 4'd1) && (rate <= 4'd8);
                        emit = 1'b1;
                    end
                end
                PH_PIC:
                begin
                    if (hdr_count == 2'd0)
                    begin
                        hdr = {16'h0, b};
                        hdr_count = 2'd1;
                    end
                    else
                    begin
                        pic_type = b[5:3];
                        u.unit_kind = KIND_PIC;
                        u.start_code_value = CODE_PICTURE;
                        u.picture_kind = pic_type;
                        u.picture_known = (pic_type >= 3'd1) && (pic_type <= 3'd3);
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    // Slide the window until it holds the full prefix
                    if (fill == 2'd2 && window == {PREFIX_ZERO, PREFIX_ZERO}
                        && b == PREFIX_ONE)
                    begin
                        phase = PH_CODE;
                        fill = 2'd0;
                        window = 16'h0;
                    end
                    else
                    begin
                        window = {window[7:0], b};
                        if (fill < 2'd2)
                            fill = fill + 2'd1;
                    end
                end
            endcase
            if (emit)
            begin
                awaited_units.push_back(u);
                restart();
            end
        endfunction

        function void compare_field(input string field, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        // Compare one transferred unit with the oldest one awaited
        function void check_unit(input mvscp_result_t got);
            mvscp_result_t want;
            if (awaited_units.size() == 0)
            begin
                $display("%0t: unexpected unit, expected none, actual kind %0d code 0x%0h",
                         $time, got.unit_kind, got.start_code_value);
                errors++;
                return;
            end
            want = awaited_units.pop_front();
            compare_field("unit_kind", 32'(want.unit_kind), 32'(got.unit_kind));
            compare_field("start_code_value", 32'(want.start_code_value),
                          32'(got.start_code_value));
            compare_field("frame_width", 32'(want.frame_width), 32'(got.frame_width));
            compare_field("frame_height", 32'(want.frame_height), 32'(got.frame_height));
            compare_field("rate_code", 32'(want.rate_code), 32'(got.rate_code));
            compare_field("rate_known", 32'(want.rate_known), 32'(got.rate_known));
            compare_field("picture_kind", 32'(want.picture_kind), 32'(got.picture_kind));
            compare_field("picture_known", 32'(want.picture_known),
                          32'(got.picture_known));
            units_checked++;
            if (want.unit_kind <= KIND_OTHER)
                kinds_seen[want.unit_kind]++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  unit_kind;
    logic [7:0]  start_code_value;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  rate_code;
    logic        rate_known;
    logic [2:0]  picture_kind;
    logic        picture_known;

    start_code_tracker_t tracker;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit hold_results = 1'b0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    mpeg_video_start_code_parser_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .stream_byte      (stream_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .unit_kind        (unit_kind),
        .start_code_value (start_code_value),
        .frame_width      (frame_width),
        .frame_height     (frame_height),
        .rate_code        (rate_code),
        .rate_known       (rate_known),
        .picture_kind     (picture_kind),
        .picture_known    (picture_known)
    );

    always #5 clk = ~clk;

    // Offer one byte, idling first at the current rate, and hold it until transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_prefix();
        send_byte(PREFIX_ZERO);
        send_byte(PREFIX_ZERO);
        send_byte(PREFIX_ONE);
    endtask

    // Emit one random unit: mostly well formed, sometimes noise or a broken prefix
    task automatic send_unit();
        logic [7:0] b;
        logic [2:0] pic_type;
        int         pick;
        int         n;
        n = $urandom_range(0, 3);
        repeat (n)
            send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                pick = $urandom_range(2);
                b = (pick == 0) ? PREFIX_ZERO : (pick == 1) ? PREFIX_ONE
                                                            : 8'($urandom_range(0, 255));
                send_byte(b);
            end
            return;
        end
        send_prefix();
        pick = $urandom_range(9);
        if (pick <= 2)
        begin
            send_byte(CODE_SEQ_HDR);
            repeat (3)
                send_byte(8'($urandom_range(0, 255)));
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(9) < 7)
                b[3:0] = 4'($urandom_range(1, 8));
            send_byte(b);
        end
        else if (pick <= 5)
        begin
            send_byte(CODE_PICTURE);
            send_byte(8'($urandom_range(0, 255)));
            b = 8'($urandom_range(0, 255));
            pic_type = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 3))
                                                : 3'($urandom_range(0, 7));
            b[5:3] = pic_type;
            send_byte(b);
        end
        else if (pick == 6)
            send_byte(CODE_GOP);
        else if (pick == 7)
            send_byte(CODE_SLICE);
        else if (pick == 8)
            send_byte(8'($urandom_range(8'h02, 8'hAF)));
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_units();
        while (tracker.awaited_units.size() != 0)
            @(posedge clk);
    endtask

    // Drive out_ready at random, or hold it low for one long stretch on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Watch both channels; feed the tracker and guard against a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_byte(stream_byte);
            if (out_valid && out_ready)
                tracker.check_unit('{unit_kind, start_code_value, frame_width,
                                     frame_height, rate_code, rate_known,
                                     picture_kind, picture_known});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] directed_stream[DIRECTED_LEN];
        int         phase_end[3];
        int         sender_pct[3];
        int         receiver_pct[3];

        // Header with all-ones sizes and unknown rate; picture whose header
        // bytes hold a prefix tail and an unknown type; group, slice; an
        // extra leading zero before a prefix and a slice-range code as other
        directed_stream = '{
            8'h00, 8'h00, 8'h01, 8'hB3, 8'hFF, 8'hFF, 8'hFF, 8'hF9,
            8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
            8'h00, 8'h00, 8'h01, 8'hB8,
            8'h00, 8'h00, 8'h01, 8'h01,
            8'h00, 8'h00, 8'h00, 8'h01, 8'hAF
        };
        phase_end = '{300, 580, 850};
        sender_pct = '{26, 80, 0};
        receiver_pct = '{80, 26, 0};

        tracker = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 3; p++)
        begin
            sender_idle_pct = sender_pct[p];
            receiver_idle_pct = receiver_pct[p];
            if (p == 0)
            begin
                foreach (directed_stream[i])
                    send_byte(directed_stream[i]);
            end
            if (p == 2)
                hold_results = 1'b1;
            while (bytes_sent < phase_end[p])
                send_unit();
            // Pause the sender until every awaited unit is out
            in_valid <= 1'b0;
            @(posedge clk);
            wait_for_units();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tracker.awaited_units.size() != 0)
        begin
            $display("%0t: %0d units never came out", $time, tracker.awaited_units.size());
            tracker.errors++;
        end

        $display("Parsed %0d bytes into %0d units: %0d seq, %0d gop, %0d pic, %0d slice,",
                 bytes_sent, tracker.units_checked, tracker.kinds_seen[KIND_SEQ],
                 tracker.kinds_seen[KIND_GOP], tracker.kinds_seen[KIND_PIC],
                 tracker.kinds_seen[KIND_SLICE]);
        $display("%0d other; ran sender-heavy, receiver-heavy and free-flowing idling",
                 tracker.kinds_seen[KIND_OTHER]);
        $display("Held results off once long enough to fill the block and stall its input");
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/mvscp_pkg.sv
design/mvscp_parser.sv
design/mpeg_video_start_code_parser_top.sv
tb/sv/testbench.sv
